FILE: rtl/core/ptw_pkg.sv
// Shared types, constants and helpers for the four-level page table walker.
package ptw_pkg;

  localparam int ADDR_W              = 52;
  localparam int VA_W                = 48;
  localparam int ENTRY_W             = 64;
  localparam int IDX_W               = 9;
  localparam int GIG_W               = ADDR_W - 30;
  localparam int FRAME_ADDR_BITS_DEF = 36;
  localparam int QUEUE_DEPTH         = 2;  // power of two, pointers wrap naturally
  localparam int PS_BIT              = 7;
  localparam int BASE_LOW_BITS       = 4;

  localparam logic ACT_REQ   = 1'b0;
  localparam logic ACT_ENTRY = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [2:0] {
    LVL_IDLE = 3'd0,
    LVL_1    = 3'd1,
    LVL_2    = 3'd2,
    LVL_3    = 3'd3,
    LVL_4    = 3'd4
  } level_t;

  // One classified item between front and back.
  // addr: masked table base for a request, frame field for an entry.
  typedef struct packed {
    logic                is_req;
    logic [VA_W-1:0]     va;
    logic [ADDR_W-1:0]   addr;
    logic                present;
    logic                big_page;
    logic [GIG_W-1:0]    gig;
  } qent_t;

  // Table index used to read the entry of the given level.
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input level_t lvl);
    logic [IDX_W-1:0] idx;
    unique case (lvl)
      LVL_1:   idx = va[47:39];
      LVL_2:   idx = va[38:30];
      LVL_3:   idx = va[29:21];
      LVL_4:   idx = va[20:12];
      default: idx = '0;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/core/ptw_front.sv
// Front end: accepts input transfers and classifies them into queue entries.
module ptw_front #(
  parameter int FRAME_ADDR_BITS = ptw_pkg::FRAME_ADDR_BITS_DEF
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_action,
  input  logic [ptw_pkg::VA_W-1:0]        in_virtual_address,
  input  logic [ptw_pkg::ADDR_W-1:0]      in_table_base,
  input  logic [ptw_pkg::ENTRY_W-1:0]     in_entry_data,
  input  logic                            q_full,
  output logic                            q_push,
  output ptw_pkg::qent_t                  q_ent
);

  localparam logic [ptw_pkg::ADDR_W-1:0] FRAME_MASK =
    ((ptw_pkg::ADDR_W'(1) << FRAME_ADDR_BITS) - ptw_pkg::ADDR_W'(1)) &
    ~ptw_pkg::ADDR_W'(12'hfff);

  logic [ptw_pkg::ADDR_W-1:0] base_masked;
  logic [ptw_pkg::ADDR_W-1:0] frame;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  assign base_masked = {in_table_base[ptw_pkg::ADDR_W-1:ptw_pkg::BASE_LOW_BITS],
                        {ptw_pkg::BASE_LOW_BITS{1'b0}}};
  assign frame       = in_entry_data[ptw_pkg::ADDR_W-1:0] & FRAME_MASK;

  always_comb begin
    q_ent.is_req   = (in_action == ptw_pkg::ACT_REQ);
    q_ent.va       = in_virtual_address;
    q_ent.addr     = (in_action == ptw_pkg::ACT_REQ) ? base_masked : frame;
    q_ent.present  = in_entry_data[0];
    q_ent.big_page = in_entry_data[ptw_pkg::PS_BIT];
    q_ent.gig      = in_entry_data[ptw_pkg::ADDR_W-1:30];
  end

endmodule

FILE: rtl/core/ptw_queue.sv
// Short flop-based queue between the front and back ends.
module ptw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ptw_pkg::qent_t push_ent,
  input  logic           pop,
  output ptw_pkg::qent_t head_ent,
  output logic           full,
  output logic           empty
);

  localparam int PTR_W = $clog2(ptw_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(ptw_pkg::QUEUE_DEPTH + 1);

  ptw_pkg::qent_t   mem_r [ptw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(ptw_pkg::QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_ent = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

endmodule

FILE: rtl/core/ptw_back.sv
// Back end: walk state, entry checks, address generation and output register.
module ptw_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_empty,
  input  ptw_pkg::qent_t             q_ent,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_kind,
  output logic [ptw_pkg::ADDR_W-1:0] out_read_address,
  output logic [ptw_pkg::ADDR_W-1:0] out_translated_address,
  output logic                       out_fault
);

  ptw_pkg::level_t            level_r, level_nxt;
  logic [ptw_pkg::VA_W-1:0]   va_r, va_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_kind_r, out_kind_nxt;
  logic [ptw_pkg::ADDR_W-1:0] out_ra_r, out_ra_nxt;
  logic [ptw_pkg::ADDR_W-1:0] out_pa_r, out_pa_nxt;
  logic                       out_fault_r, out_fault_nxt;

  logic                       load_ok;
  logic                       res_valid;
  ptw_pkg::level_t            lvl_step;
  logic [ptw_pkg::IDX_W-1:0]  idx;

  assign load_ok = !out_valid_r || out_ready;
  assign q_pop   = load_ok && !q_empty;

  assign out_valid              = out_valid_r;
  assign out_kind               = out_kind_r;
  assign out_read_address       = out_ra_r;
  assign out_translated_address = out_pa_r;
  assign out_fault              = out_fault_r;

  always_comb begin
    level_nxt     = level_r;
    va_nxt        = va_r;
    res_valid     = 1'b0;
    out_kind_nxt  = ptw_pkg::KIND_READ;
    out_ra_nxt    = '0;
    out_pa_nxt    = '0;
    out_fault_nxt = 1'b0;
    lvl_step      = ptw_pkg::LVL_IDLE;
    idx           = '0;

    if (q_pop) begin
      if (q_ent.is_req) begin
        // a request during a walk is dropped
        if (level_r == ptw_pkg::LVL_IDLE) begin
          idx        = ptw_pkg::va_index(q_ent.va, ptw_pkg::LVL_1);
          va_nxt     = q_ent.va;
          level_nxt  = ptw_pkg::LVL_1;
          res_valid  = 1'b1;
          out_ra_nxt = q_ent.addr + ptw_pkg::ADDR_W'({idx, 3'b000});
        end
      end else if (level_r != ptw_pkg::LVL_IDLE) begin
        res_valid = 1'b1;
        unique case (level_r)
          ptw_pkg::LVL_1:   lvl_step = ptw_pkg::LVL_2;
          ptw_pkg::LVL_2:   lvl_step = ptw_pkg::LVL_3;
          ptw_pkg::LVL_3:   lvl_step = ptw_pkg::LVL_4;
          default:          lvl_step = ptw_pkg::LVL_IDLE;
        endcase
        idx = ptw_pkg::va_index(va_r, lvl_step);

        if (!q_ent.present) begin
          out_kind_nxt  = ptw_pkg::KIND_DONE;
          out_fault_nxt = 1'b1;
          level_nxt     = ptw_pkg::LVL_IDLE;
        end else if (level_r == ptw_pkg::LVL_2 && q_ent.big_page) begin
          out_kind_nxt = ptw_pkg::KIND_DONE;
          out_pa_nxt   = {q_ent.gig, va_r[29:0]};
          level_nxt    = ptw_pkg::LVL_IDLE;
        end else if (level_r == ptw_pkg::LVL_3 && q_ent.big_page) begin
          out_kind_nxt = ptw_pkg::KIND_DONE;
          out_pa_nxt   = {q_ent.addr[ptw_pkg::ADDR_W-1:21], va_r[20:0]};
          level_nxt    = ptw_pkg::LVL_IDLE;
        end else if (level_r == ptw_pkg::LVL_4) begin
          out_kind_nxt = ptw_pkg::KIND_DONE;
          level_nxt    = ptw_pkg::LVL_IDLE;
          if (q_ent.addr == '0) begin
            out_fault_nxt = 1'b1;
          end else begin
            out_pa_nxt = {q_ent.addr[ptw_pkg::ADDR_W-1:12], va_r[11:0]};
          end
        end else begin
          level_nxt  = lvl_step;
          out_ra_nxt = q_ent.addr + ptw_pkg::ADDR_W'({idx, 3'b000});
        end
      end
    end

    out_valid_nxt = load_ok ? res_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= ptw_pkg::LVL_IDLE;
      va_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      va_r        <= va_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok && res_valid) begin
      out_kind_r  <= out_kind_nxt;
      out_ra_r    <= out_ra_nxt;
      out_pa_r    <= out_pa_nxt;
      out_fault_r <= out_fault_nxt;
    end
  end

endmodule

FILE: rtl/core/four_level_page_table_walker_core.sv
// Top level of the four-level page table walker: front end, queue, back end.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  in      | input     | in_valid / in_ready    | action, virtual_address, table_base, entry
//  out     | output    | out_valid / out_ready  | kind, read_address, translated_address, fault
//
// One item per cycle sustained while out_ready stays high; an item that finds the queue
// empty is classified into the queue at its transfer edge, and its walk step is then
// registered into the output register that drives out_valid. The back end's single
// walk-state register sets the rate.
// Reset (rst_n low, synchronous) empties the queue, drops the walk and clears out_valid.
// A stalled output holds; in_ready falls only when the two-entry queue is full.
module four_level_page_table_walker_core #(
  parameter int FRAME_ADDR_BITS = ptw_pkg::FRAME_ADDR_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [ptw_pkg::VA_W-1:0]    in_virtual_address,
  input  logic [ptw_pkg::ADDR_W-1:0]  in_table_base,
  input  logic [ptw_pkg::ENTRY_W-1:0] in_entry_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [ptw_pkg::ADDR_W-1:0]  out_read_address,
  output logic [ptw_pkg::ADDR_W-1:0]  out_translated_address,
  output logic                        out_fault
);

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  ptw_pkg::qent_t push_ent;
  ptw_pkg::qent_t head_ent;

  ptw_front #(
    .FRAME_ADDR_BITS (FRAME_ADDR_BITS)
  ) u_front (
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_virtual_address (in_virtual_address),
    .in_table_base      (in_table_base),
    .in_entry_data      (in_entry_data),
    .q_full             (q_full),
    .q_push             (q_push),
    .q_ent              (push_ent)
  );

  ptw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .head_ent (head_ent),
    .full     (q_full),
    .empty    (q_empty)
  );

  ptw_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_empty                (q_empty),
    .q_ent                  (head_ent),
    .q_pop                  (q_pop),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_kind               (out_kind),
    .out_read_address       (out_read_address),
    .out_translated_address (out_translated_address),
    .out_fault              (out_fault)
  );

endmodule

FILE: rtl/core/ptw_checker.sv
// Port-level checks for the page table walker, bound to the top level.
module ptw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [ptw_pkg::ADDR_W-1:0]  out_read_address,
  input logic [ptw_pkg::ADDR_W-1:0]  out_translated_address,
  input logic                        out_fault
);

  // result held until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped before transfer");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_READ |->
      !out_fault && out_translated_address == '0)
    else $error("read request carries completion fields");

  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == ptw_pkg::KIND_DONE |-> out_read_address == '0)
    else $error("completion carries a read address");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> out_translated_address == '0)
    else $error("faulted walk reports an address");

endmodule

bind four_level_page_table_walker_core ptw_checker u_ptw_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_kind               (out_kind),
  .out_read_address       (out_read_address),
  .out_translated_address (out_translated_address),
  .out_fault              (out_fault)
);
